// ----- rtl/core/bsm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared types and codes for the bank switch mapper with scanline IRQ.
// ----------------------------------------------------------------------------
package bsm_pkg;

  localparam int CMD_W    = 3;
  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 8;
  localparam int MAP_W    = 19;
  localparam int PBANK_W  = 6;
  localparam int CBANK_W  = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CMD_W-1:0] CMD_CPU_READ  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CPU_WRITE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PPU_READ  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SCANLINE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_IRQ_ACK   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_PRG_BANKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_RAM   = 1'd1;

  // CPU register groups, address bits 14..13
  localparam logic [1:0] GRP_BANK   = 2'd0;
  localparam logic [1:0] GRP_MIRROR = 2'd1;
  localparam logic [1:0] GRP_IRQ_LD = 2'd2;
  localparam logic [1:0] GRP_IRQ_EN = 2'd3;

  localparam logic [PBANK_W-1:0] PRG_BANKS_RST = 6'd2;

  typedef struct packed {
    logic [3:0][PBANK_W-1:0] prg_tbl;
    logic [7:0][CBANK_W-1:0] chr_tbl;
    logic                    chr_is_ram;
  } map_state_t;

endpackage
`default_nettype wire

// ----- rtl/core/bsm_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsm_regs
// Mapper register file: bank registers, bank tables, mirroring, IRQ counter.
// ----------------------------------------------------------------------------
module bsm_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [bsm_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [7:0]                    cfg_wdata,
  input  wire logic                          exec,
  input  wire logic [bsm_pkg::CMD_W-1:0]     cmd,
  input  wire logic [bsm_pkg::ADDR_W-1:0]    addr,
  input  wire logic [bsm_pkg::DATA_W-1:0]    wdata,
  output bsm_pkg::map_state_t                map_st,
  output logic                               irq_nxt,
  output logic                               mirror_nxt
);
  import bsm_pkg::*;

  logic [7:0][DATA_W-1:0]  bank_r,   bank_nxt;
  logic [2:0]              sel_r,    sel_nxt;
  logic                    pmode_r,  pmode_nxt;
  logic                    cinv_r,   cinv_nxt;
  logic [3:0][PBANK_W-1:0] prg_r,    prg_nxt;
  logic [7:0][CBANK_W-1:0] chr_r,    chr_nxt;
  logic                    mirror_r;
  logic [7:0]              cnt_r,    cnt_nxt;
  logic [7:0]              reload_r, reload_nxt;
  logic                    en_r,     en_nxt;
  logic                    irq_r;
  logic [PBANK_W-1:0]      nbanks_r, nbanks_nxt;
  logic                    cram_r,   cram_nxt;

  logic [PBANK_W-1:0] second_last, last_bank;
  logic [PBANK_W-1:0] cfg_second_last;
  logic [CBANK_W-1:0] c0, c2;
  logic [7:0]         cnt_step;
  logic               odd;

  assign second_last     = {nbanks_r[4:0], 1'b0} - 6'd2;
  assign last_bank       = second_last | 6'd1;
  assign cfg_second_last = {cfg_wdata[4:0], 1'b0} - 6'd2;
  assign odd             = addr[0];
  assign cnt_step        = (cnt_r == 8'd0) ? reload_r : cnt_r - 8'd1;

  always_comb begin
    bank_nxt   = bank_r;
    sel_nxt    = sel_r;
    pmode_nxt  = pmode_r;
    cinv_nxt   = cinv_r;
    prg_nxt    = prg_r;
    chr_nxt    = chr_r;
    mirror_nxt = mirror_r;
    cnt_nxt    = cnt_r;
    reload_nxt = reload_r;
    en_nxt     = en_r;
    irq_nxt    = irq_r;
    nbanks_nxt = nbanks_r;
    cram_nxt   = cram_r;
    c0         = '0;
    c2         = '0;

    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_PRG_BANKS: begin
          nbanks_nxt = cfg_wdata[PBANK_W-1:0];
          prg_nxt[0] = 6'd0;
          prg_nxt[1] = 6'd1;
          prg_nxt[2] = cfg_second_last;
          prg_nxt[3] = cfg_second_last | 6'd1;
        end
        CFG_CHR_RAM: cram_nxt = cfg_wdata[0];
        default: ;
      endcase
    end

    if (exec) begin
      unique case (cmd)
        CMD_CPU_WRITE: begin
          if (addr[15]) begin
            unique case (addr[14:13])
              GRP_BANK: begin
                if (!odd) begin
                  sel_nxt   = wdata[2:0];
                  pmode_nxt = wdata[6];
                  cinv_nxt  = wdata[7];
                end else begin
                  bank_nxt[sel_r] = wdata;
                  c0 = bank_nxt[0] & 8'hFE;
                  c2 = bank_nxt[1] & 8'hFE;
                  if (cinv_r) begin
                    chr_nxt[4] = c0;
                    chr_nxt[5] = c0 | 8'd1;
                    chr_nxt[6] = c2;
                    chr_nxt[7] = c2 | 8'd1;
                    chr_nxt[0] = bank_nxt[2];
                    chr_nxt[1] = bank_nxt[3];
                    chr_nxt[2] = bank_nxt[4];
                    chr_nxt[3] = bank_nxt[5];
                  end else begin
                    chr_nxt[0] = c0;
                    chr_nxt[1] = c0 | 8'd1;
                    chr_nxt[2] = c2;
                    chr_nxt[3] = c2 | 8'd1;
                    chr_nxt[4] = bank_nxt[2];
                    chr_nxt[5] = bank_nxt[3];
                    chr_nxt[6] = bank_nxt[4];
                    chr_nxt[7] = bank_nxt[5];
                  end
                  if (pmode_r) begin
                    prg_nxt[0] = second_last;
                    prg_nxt[2] = bank_nxt[6][PBANK_W-1:0];
                  end else begin
                    prg_nxt[0] = bank_nxt[6][PBANK_W-1:0];
                    prg_nxt[2] = second_last;
                  end
                  prg_nxt[1] = bank_nxt[7][PBANK_W-1:0];
                  prg_nxt[3] = last_bank;
                end
              end
              GRP_MIRROR: begin
                if (!odd) mirror_nxt = wdata[0];
              end
              GRP_IRQ_LD: begin
                if (!odd) reload_nxt = wdata;
                else      cnt_nxt    = 8'd0;
              end
              GRP_IRQ_EN: begin
                if (!odd) begin
                  en_nxt  = 1'b0;
                  irq_nxt = 1'b0;
                end else begin
                  en_nxt  = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        CMD_SCANLINE: begin
          cnt_nxt = cnt_step;
          if (cnt_step == 8'd0 && en_r) irq_nxt = 1'b1;
        end
        CMD_IRQ_ACK: irq_nxt = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r   <= '0;
      sel_r    <= '0;
      pmode_r  <= 1'b0;
      cinv_r   <= 1'b0;
      prg_r[0] <= 6'd0;
      prg_r[1] <= 6'd1;
      prg_r[2] <= {PRG_BANKS_RST[4:0], 1'b0} - 6'd2;
      prg_r[3] <= {PRG_BANKS_RST[4:0], 1'b0} - 6'd1;
      chr_r    <= '0;
      mirror_r <= 1'b0;
      cnt_r    <= '0;
      reload_r <= '0;
      en_r     <= 1'b0;
      irq_r    <= 1'b0;
      nbanks_r <= PRG_BANKS_RST;
      cram_r   <= 1'b0;
    end else begin
      bank_r   <= bank_nxt;
      sel_r    <= sel_nxt;
      pmode_r  <= pmode_nxt;
      cinv_r   <= cinv_nxt;
      prg_r    <= prg_nxt;
      chr_r    <= chr_nxt;
      mirror_r <= mirror_nxt;
      cnt_r    <= cnt_nxt;
      reload_r <= reload_nxt;
      en_r     <= en_nxt;
      irq_r    <= irq_nxt;
      nbanks_r <= nbanks_nxt;
      cram_r   <= cram_nxt;
    end
  end

  assign map_st.prg_tbl    = prg_r;
  assign map_st.chr_tbl    = chr_r;
  assign map_st.chr_is_ram = cram_r;

endmodule
`default_nettype wire

// ----- rtl/core/bsm_xlat.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsm_xlat
// Address translation; program and pattern ROM reads use the bank tables.
// ----------------------------------------------------------------------------
module bsm_xlat (
  input  wire logic [bsm_pkg::CMD_W-1:0]  cmd,
  input  wire logic [bsm_pkg::ADDR_W-1:0] addr,
  input  wire bsm_pkg::map_state_t        map_st,
  output logic [bsm_pkg::MAP_W-1:0]       mapped
);
  import bsm_pkg::*;

  always_comb begin
    mapped = '0;
    case (cmd)
      CMD_CPU_READ: begin
        if (addr[15]) mapped = {map_st.prg_tbl[addr[14:13]], addr[12:0]};
      end
      CMD_PPU_READ: begin
        if (map_st.chr_is_ram) begin
          mapped = {3'd0, addr};
        end else if (addr[15:13] == 3'd0) begin
          mapped = {1'b0, map_st.chr_tbl[addr[12:10]], addr[9:0]};
        end
      end
      default: mapped = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/bank_switch_mapper_scanline_irq_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bank_switch_mapper_scanline_irq_unit
// Bank switching mapper: program/pattern address translation, CPU register
// writes, scanline IRQ counter.
// ----------------------------------------------------------------------------
//  channel | signals                                       | dir
//  in      | in_valid/in_ready, in_command/address/write_data | in
//  out     | out_valid/out_ready, out_mapped_address,        | out
//          | out_irq_active, out_mirror_horizontal           |
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data        | in
//
// One item per cycle unless the output stalls; an item passes the input register, then the result register.
// Translation and state update run in the cycle between the two registers.
// A stalled result register holds the input register; in_ready stays high
// while the input stage is empty or can move. cfg_ready is always high.
// Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
module bank_switch_mapper_scanline_irq_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [bsm_pkg::CMD_W-1:0]     in_command,
  input  wire logic [bsm_pkg::ADDR_W-1:0]    in_address,
  input  wire logic [bsm_pkg::DATA_W-1:0]    in_write_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [bsm_pkg::MAP_W-1:0]          out_mapped_address,
  output logic                               out_irq_active,
  output logic                               out_mirror_horizontal,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                    cfg_data
);
  import bsm_pkg::*;

  logic              s1_valid_r;
  logic [CMD_W-1:0]  s1_cmd_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [DATA_W-1:0] s1_data_r;
  logic              s1_adv;
  logic              exec;

  logic              out_valid_r;
  logic [MAP_W-1:0]  out_map_r;
  logic              out_irq_r;
  logic              out_mir_r;

  map_state_t        map_st;
  logic              irq_nxt;
  logic              mirror_nxt;
  logic [MAP_W-1:0]  mapped;

  assign s1_adv    = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || s1_adv;
  assign exec      = s1_valid_r && s1_adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_cmd_r  <= in_command;
      s1_addr_r <= in_address;
      s1_data_r <= in_write_data;
    end
  end

  bsm_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .exec      (exec),
    .cmd       (s1_cmd_r),
    .addr      (s1_addr_r),
    .wdata     (s1_data_r),
    .map_st    (map_st),
    .irq_nxt   (irq_nxt),
    .mirror_nxt(mirror_nxt)
  );

  bsm_xlat u_xlat (
    .cmd    (s1_cmd_r),
    .addr   (s1_addr_r),
    .map_st (map_st),
    .mapped (mapped)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_map_r <= mapped;
      out_irq_r <= irq_nxt;
      out_mir_r <= mirror_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_mapped_address    = out_map_r;
  assign out_irq_active        = out_irq_r;
  assign out_mirror_horizontal = out_mir_r;

endmodule
`default_nettype wire

// ----- tb/sv/bank_map_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bank_map_checker
// Watches the command, result and register channels of the bank switch
// mapper, keeps its own copy of the bank tables and IRQ counter, predicts
// the result of every accepted command and compares it with the returned
// result, oldest first.
// ----------------------------------------------------------------------------
module bank_map_checker
  import bsm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [ADDR_W-1:0]    in_address,
  input  logic [DATA_W-1:0]    in_write_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [MAP_W-1:0]     out_mapped_address,
  input  logic                 out_irq_active,
  input  logic                 out_mirror_horizontal,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    logic [MAP_W-1:0] mapped;
    logic             irq;
    logic             mirror;
  } map_result_t;

  map_result_t        expected_q[$];
  int                 errors;

  logic [7:0]         bank_reg [8];
  logic [2:0]         sel_idx;
  logic               prg_mode;
  logic               chr_invert;
  logic [PBANK_W-1:0] prg_tbl [4];
  logic [CBANK_W-1:0] chr_tbl [8];
  logic               mirror_h;
  logic [7:0]         irq_cnt;
  logic [7:0]         irq_rld;
  logic               irq_en;
  logic               irq_line;
  logic [PBANK_W-1:0] prg_banks;
  logic               chr_ram;

  initial begin
    errors     = 0;
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic [PBANK_W-1:0] fixed_bank(input logic last);
    logic [PBANK_W-1:0] twice;
    twice = {prg_banks[PBANK_W-2:0], 1'b0};
    return last ? twice - 6'd1 : twice - 6'd2;
  endfunction

  task automatic load_prg_default();
    prg_tbl[0] = 6'd0;
    prg_tbl[1] = 6'd1;
    prg_tbl[2] = fixed_bank(1'b0);
    prg_tbl[3] = fixed_bank(1'b1);
  endtask

  task automatic reset_model();
    for (int i = 0; i < 8; i++) begin
      bank_reg[i] = '0;
      chr_tbl[i]  = '0;
    end
    sel_idx    = '0;
    prg_mode   = 1'b0;
    chr_invert = 1'b0;
    mirror_h   = 1'b0;
    irq_cnt    = '0;
    irq_rld    = '0;
    irq_en     = 1'b0;
    irq_line   = 1'b0;
    prg_banks  = PRG_BANKS_RST;
    chr_ram    = 1'b0;
    load_prg_default();
  endtask

  task automatic rebuild_tables();
    int lo;
    int hi;
    lo = chr_invert ? 4 : 0;
    hi = chr_invert ? 0 : 4;
    chr_tbl[lo]     = bank_reg[0] & 8'hFE;
    chr_tbl[lo + 1] = (bank_reg[0] & 8'hFE) + 8'd1;
    chr_tbl[lo + 2] = bank_reg[1] & 8'hFE;
    chr_tbl[lo + 3] = (bank_reg[1] & 8'hFE) + 8'd1;
    for (int i = 0; i < 4; i++) chr_tbl[hi + i] = bank_reg[2 + i];
    if (prg_mode) begin
      prg_tbl[0] = fixed_bank(1'b0);
      prg_tbl[2] = bank_reg[6][PBANK_W-1:0];
    end else begin
      prg_tbl[0] = bank_reg[6][PBANK_W-1:0];
      prg_tbl[2] = fixed_bank(1'b0);
    end
    prg_tbl[1] = bank_reg[7][PBANK_W-1:0];
    prg_tbl[3] = fixed_bank(1'b1);
  endtask

  task automatic cpu_register_write(input logic [ADDR_W-1:0] addr, input logic [7:0] wd);
    if (addr[15]) begin
      case (addr[14:13])
        GRP_BANK: begin
          if (!addr[0]) begin
            sel_idx    = wd[2:0];
            prg_mode   = wd[6];
            chr_invert = wd[7];
          end else begin
            bank_reg[sel_idx] = wd;
            rebuild_tables();
          end
        end
        GRP_MIRROR: begin
          if (!addr[0]) mirror_h = wd[0];
        end
        GRP_IRQ_LD: begin
          if (!addr[0]) irq_rld = wd;
          else irq_cnt = '0;
        end
        default: begin
          if (!addr[0]) begin
            irq_en   = 1'b0;
            irq_line = 1'b0;
          end else begin
            irq_en = 1'b1;
          end
        end
      endcase
    end
  endtask

  task automatic translate_and_update(input logic [CMD_W-1:0] cmd,
                                      input logic [ADDR_W-1:0] addr,
                                      input logic [DATA_W-1:0] wd,
                                      output map_result_t res);
    logic [MAP_W-1:0] mapped;
    mapped = '0;
    case (cmd)
      CMD_CPU_READ: begin
        if (addr[15]) mapped = {prg_tbl[addr[14:13]], addr[12:0]};
      end
      CMD_CPU_WRITE: cpu_register_write(addr, wd);
      CMD_PPU_READ: begin
        if (chr_ram) mapped = MAP_W'(addr);
        else if (addr < 16'h2000) mapped = MAP_W'({chr_tbl[addr[12:10]], addr[9:0]});
      end
      CMD_SCANLINE: begin
        if (irq_cnt == 8'd0) irq_cnt = irq_rld;
        else irq_cnt = irq_cnt - 8'd1;
        if (irq_cnt == 8'd0 && irq_en) irq_line = 1'b1;
      end
      CMD_IRQ_ACK: irq_line = 1'b0;
      default: ;
    endcase
    res = '{mapped: mapped, irq: irq_line, mirror: mirror_h};
  endtask

  task automatic note_error(input string what, input map_result_t want, input map_result_t got);
    if (errors < 10)
      $display("%0t: %s: expected map=%05h irq=%0b mir=%0b, got map=%05h irq=%0b mir=%0b",
               $time, what, want.mapped, want.irq, want.mirror,
               got.mapped, got.irq, got.mirror);
    errors++;
  endtask

  always @(posedge clk) begin
    map_result_t want;
    map_result_t got;
    if (!rst_n) begin
      reset_model();
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PRG_BANKS) begin
          prg_banks = cfg_data[PBANK_W-1:0];
          load_prg_default();
        end else if (cfg_index == CFG_CHR_RAM) begin
          chr_ram = cfg_data[0];
        end
      end
      if (in_valid && in_ready) begin
        translate_and_update(in_command, in_address, in_write_data, want);
        expected_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = '{mapped: out_mapped_address, irq: out_irq_active,
                mirror: out_mirror_horizontal};
        if (expected_q.size() == 0) begin
          note_error("result with no item pending", '0, got);
        end else begin
          want = expected_q.pop_front();
          if (want.mapped !== got.mapped || want.irq !== got.irq ||
              want.mirror !== got.mirror)
            note_error("result mismatch", want, got);
        end
      end
    end
    pending    <= expected_q.size();
    fail_count <= errors;
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the bank switch mapper with directed commands at the edges of the
// address map and the IRQ counter, then random command streams under several
// register settings and idle patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import bsm_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 180;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     in_command = '0;
  logic [ADDR_W-1:0]    in_address = '0;
  logic [DATA_W-1:0]    in_write_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  logic [MAP_W-1:0]     out_mapped_address;
  logic                 out_irq_active;
  logic                 out_mirror_horizontal;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  int fail_count;
  int pending;
  int in_gap_pct = 0;
  int out_stall_pct = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  bank_switch_mapper_scanline_irq_unit u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_command            (in_command),
    .in_address            (in_address),
    .in_write_data         (in_write_data),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_mapped_address    (out_mapped_address),
    .out_irq_active        (out_irq_active),
    .out_mirror_horizontal (out_mirror_horizontal),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  bank_map_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_command            (in_command),
    .in_address            (in_address),
    .in_write_data         (in_write_data),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_mapped_address    (out_mapped_address),
    .out_irq_active        (out_irq_active),
    .out_mirror_horizontal (out_mirror_horizontal),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .fail_count            (fail_count),
    .pending               (pending)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("** bank_switch_mapper_scanline_irq_unit: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                           input logic [DATA_W-1:0] wd);
    while ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_address    <= addr;
    in_write_data <= wd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] banks_data, input logic [7:0] ram_data);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_PRG_BANKS;
    cfg_data  <= banks_data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_CHR_RAM;
    cfg_data  <= ram_data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int count);
    int               pick;
    logic [CMD_W-1:0] cmd;
    logic [15:0]      addr;
    logic [7:0]       wd;
    for (int k = 0; k < count; k++) begin
      if (k == count / 2) drain_results();
      pick = $urandom_range(0, 99);
      addr = 16'($urandom);
      wd   = 8'($urandom);
      if (pick < 22) begin
        cmd = CMD_CPU_READ;
        if (pick < 19) addr[15] = 1'b1;
      end else if (pick < 44) begin
        cmd = CMD_PPU_READ;
        if (pick < 40) addr[15:13] = 3'd0;
      end else if (pick < 56) begin
        // bank select followed by its data write
        send_item(CMD_CPU_WRITE, {1'b1, GRP_BANK, addr[12:1], 1'b0}, wd);
        cmd  = CMD_CPU_WRITE;
        addr = {1'b1, GRP_BANK, 12'($urandom), 1'b1};
        wd   = 8'($urandom);
      end else if (pick < 70) begin
        cmd = CMD_CPU_WRITE;
        addr[15] = 1'b1;
        if (addr[14:13] == GRP_IRQ_LD && !addr[0] && $urandom_range(0, 3) != 0)
          wd = 8'($urandom_range(0, 4));
        if (addr[14:13] == GRP_IRQ_EN && $urandom_range(0, 2) != 0)
          addr[0] = 1'b1;
      end else if (pick < 72) begin
        cmd = CMD_CPU_WRITE;
      end else if (pick < 90) begin
        cmd = CMD_SCANLINE;
      end else if (pick < 95) begin
        cmd = CMD_IRQ_ACK;
      end else begin
        cmd = CMD_W'($urandom_range(5, 7));
      end
      send_item(cmd, addr, wd);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset tables, window edges, low addresses
    send_item(CMD_CPU_READ, 16'h8000, 8'h00);
    send_item(CMD_CPU_READ, 16'hFFFF, 8'h00);
    send_item(CMD_CPU_READ, 16'h7FFF, 8'hFF);
    send_item(CMD_PPU_READ, 16'h1FFF, 8'h00);
    send_item(CMD_PPU_READ, 16'h2000, 8'h00);
    send_item(CMD_CPU_WRITE, 16'h6000, 8'hFF);
    // mode bits set, bank 7 full byte, then odd value in a 2 KB pair
    send_item(CMD_CPU_WRITE, 16'h8000, 8'hC7);
    send_item(CMD_CPU_WRITE, 16'h8001, 8'hFF);
    send_item(CMD_CPU_READ, 16'hA123, 8'h00);
    send_item(CMD_CPU_WRITE, 16'h9FFE, 8'h80);
    send_item(CMD_CPU_WRITE, 16'h9FFF, 8'h81);
    send_item(CMD_PPU_READ, 16'h0000, 8'h00);
    send_item(CMD_PPU_READ, 16'h17FF, 8'h00);
    send_item(CMD_CPU_READ, 16'hC000, 8'h00);
    // mirroring, ignored protect write
    send_item(CMD_CPU_WRITE, 16'hA000, 8'h01);
    send_item(CMD_CPU_WRITE, 16'hA001, 8'h00);
    // IRQ counter: reload 2, enable, count down, clear, acknowledge
    send_item(CMD_CPU_WRITE, 16'hC000, 8'h02);
    send_item(CMD_CPU_WRITE, 16'hE001, 8'h00);
    send_item(CMD_SCANLINE, 16'h0000, 8'h00);
    send_item(CMD_SCANLINE, 16'h0000, 8'h00);
    send_item(CMD_SCANLINE, 16'hFFFF, 8'hFF);
    send_item(CMD_CPU_WRITE, 16'hC001, 8'h00);
    send_item(CMD_IRQ_ACK, 16'h0000, 8'h00);
    send_item(CMD_CPU_WRITE, 16'hE000, 8'h00);
    send_item(CMD_W'(7), 16'hFFFF, 8'hFF);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_config(8'h20, 8'h00);
        1: set_config(8'h01, 8'h01);
        2: set_config(8'hC0, 8'hFE);
        3: set_config(8'h3F, 8'hFF);
        4: set_config(8'($urandom_range(1, 32)) | 8'($urandom_range(0, 3) << 6),
                      8'($urandom));
        default: set_config(8'h02, 8'h00);
      endcase
      case (p % 4)
        0: begin in_gap_pct = 0;  out_stall_pct = 0;  end
        1: begin in_gap_pct = 50; out_stall_pct = 0;  end
        2: begin in_gap_pct = 0;  out_stall_pct = 50; end
        default: begin in_gap_pct = 14; out_stall_pct = 14; end
      endcase
      run_random(PHASE_ITEMS);
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("** bank_switch_mapper_scanline_irq_unit: PASSED **");
    else
      $display("** bank_switch_mapper_scanline_irq_unit: FAILED **");
    $finish;
  end

endmodule
